// ===== design/qbbb_pkg.sv =====
// Package for the quadratic Bezier bounding box block: default widths.
// No dependencies; used by every module of the block.
package qbbb_pkg;

    // coordinate width and fraction bits of the curve parameter t
    localparam int DEF_COORD_BITS  = 16;
    localparam int DEF_T_FRAC_BITS = 16;

endpackage

// ===== design/quadratic_bezier_bounding_box_top.sv =====
// Top level of the quadratic Bezier bounding box block.
// Depends on qbbb_pkg, qbbb_div and qbbb_eval.
//
// Usage:
//   Drive the three control points on the i_* coordinate ports and raise
//   start for one cycle per item. busy is always low: an item is taken in
//   every cycle that start is high.
//   The box appears on o_min_x, o_min_y, o_max_x, o_max_y for exactly one
//   cycle, marked by o_valid. Results leave in input order.
//   Throughput: one item per cycle. Each item passes one setup stage, the
//   divider that forms t with one quotient bit per stage, three evaluator
//   stages and two merge stages.
//   The receiver cannot stall; results are never held.
//   Reset (i_rst_n low, synchronous) clears all valid bits, so no result
//   strobes after reset until new items arrive.
module quadratic_bezier_bounding_box_top #(
    parameter int COORD_BITS  = qbbb_pkg::DEF_COORD_BITS,
    parameter int T_FRAC_BITS = qbbb_pkg::DEF_T_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_ctrl_x,
    input  logic signed [COORD_BITS-1:0] i_ctrl_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_valid,
    output logic signed [COORD_BITS-1:0] o_min_x,
    output logic signed [COORD_BITS-1:0] o_min_y,
    output logic signed [COORD_BITS-1:0] o_max_x,
    output logic signed [COORD_BITS-1:0] o_max_y
);
    import qbbb_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int DW    = COORD_BITS + 2;
    localparam int SW    = 6 * COORD_BITS + 2;
    localparam int DEPTH = T_FRAC_BITS + 4;

    // setup: numerator, denominator and interior test per axis
    logic signed [DW-1:0] w_nx, w_dx, w_ny, w_dy;
    logic [DW-1:0]        w_anx, w_adx, w_any, w_ady;
    logic                 w_ix, w_iy;

    assign w_nx  = DW'(i_start_x) - DW'(i_ctrl_x);
    assign w_dx  = DW'(i_start_x) - (DW'(i_ctrl_x) <<< 1) + DW'(i_end_x);
    assign w_ny  = DW'(i_start_y) - DW'(i_ctrl_y);
    assign w_dy  = DW'(i_start_y) - (DW'(i_ctrl_y) <<< 1) + DW'(i_end_y);
    assign w_anx = w_nx[DW-1] ? DW'(-w_nx) : DW'(w_nx);
    assign w_adx = w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
    assign w_any = w_ny[DW-1] ? DW'(-w_ny) : DW'(w_ny);
    assign w_ady = w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
    assign w_ix  = (w_nx != '0) && (w_dx != '0) && (w_nx[DW-1] == w_dx[DW-1])
                && (w_anx < w_adx);
    assign w_iy  = (w_ny != '0) && (w_dy != '0) && (w_ny[DW-1] == w_dy[DW-1])
                && (w_any < w_ady);

    logic [DW-1:0] r_anx, r_adx, r_any, r_ady;
    logic [SW-1:0] r_side [DEPTH];
    logic          r_vld  [DEPTH];

    always_ff @(posedge i_clk) begin
        r_anx     <= w_anx;
        r_adx     <= w_adx;
        r_any     <= w_any;
        r_ady     <= w_ady;
        r_side[0] <= {w_ix, w_iy, i_start_x, i_start_y, i_ctrl_x, i_ctrl_y,
                      i_end_x, i_end_y};
        for (int k = 1; k < DEPTH; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // advance valid bits with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start;
            for (int k = 1; k < DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // t per axis
    logic [T_FRAC_BITS-1:0] w_tqx, w_tqy;

    qbbb_div #(.DEN_BITS(DW), .QUO_BITS(T_FRAC_BITS)) u_div_x (
        .i_clk (i_clk), .i_num (r_anx), .i_den (r_adx), .o_quo (w_tqx)
    );
    qbbb_div #(.DEN_BITS(DW), .QUO_BITS(T_FRAC_BITS)) u_div_y (
        .i_clk (i_clk), .i_num (r_any), .i_den (r_ady), .o_quo (w_tqy)
    );

    // evaluate the curve at both parameters
    logic [SW-1:0]          w_se;
    logic signed [CW-1:0]   w_ax, w_ay, w_bx, w_by, w_cx, w_cy;
    logic signed [CW-1:0]   w_pxx, w_pxy, w_pyx, w_pyy;

    assign w_se = r_side[T_FRAC_BITS];
    assign w_ax = $signed(w_se[5*CW +: CW]);
    assign w_ay = $signed(w_se[4*CW +: CW]);
    assign w_bx = $signed(w_se[3*CW +: CW]);
    assign w_by = $signed(w_se[2*CW +: CW]);
    assign w_cx = $signed(w_se[1*CW +: CW]);
    assign w_cy = $signed(w_se[0 +: CW]);

    qbbb_eval #(.COORD_BITS(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_ev_xx (
        .i_clk (i_clk), .i_a (w_ax), .i_b (w_bx), .i_c (w_cx), .i_tq (w_tqx),
        .o_p (w_pxx)
    );
    qbbb_eval #(.COORD_BITS(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_ev_xy (
        .i_clk (i_clk), .i_a (w_ay), .i_b (w_by), .i_c (w_cy), .i_tq (w_tqx),
        .o_p (w_pxy)
    );
    qbbb_eval #(.COORD_BITS(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_ev_yx (
        .i_clk (i_clk), .i_a (w_ax), .i_b (w_bx), .i_c (w_cx), .i_tq (w_tqy),
        .o_p (w_pyx)
    );
    qbbb_eval #(.COORD_BITS(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_ev_yy (
        .i_clk (i_clk), .i_a (w_ay), .i_b (w_by), .i_c (w_cy), .i_tq (w_tqy),
        .o_p (w_pyy)
    );

    // merge endpoints and x-axis extremum point
    logic [SW-1:0]        w_sm;
    logic signed [CW-1:0] w_eax, w_eay, w_ecx, w_ecy;
    logic signed [CW-1:0] n_lox, n_hix, n_loy, n_hiy;
    logic                 w_mix, w_miy;

    assign w_sm  = r_side[DEPTH-1];
    assign w_mix = w_sm[SW-1];
    assign w_miy = w_sm[SW-2];
    assign w_eax = $signed(w_sm[5*CW +: CW]);
    assign w_eay = $signed(w_sm[4*CW +: CW]);
    assign w_ecx = $signed(w_sm[1*CW +: CW]);
    assign w_ecy = $signed(w_sm[0 +: CW]);

    always_comb begin
        n_lox = (w_eax < w_ecx) ? w_eax : w_ecx;
        n_hix = (w_eax < w_ecx) ? w_ecx : w_eax;
        n_loy = (w_eay < w_ecy) ? w_eay : w_ecy;
        n_hiy = (w_eay < w_ecy) ? w_ecy : w_eay;
        if (w_mix) begin
            if (w_pxx < n_lox) n_lox = w_pxx;
            if (w_pxx > n_hix) n_hix = w_pxx;
            if (w_pxy < n_loy) n_loy = w_pxy;
            if (w_pxy > n_hiy) n_hiy = w_pxy;
        end
    end

    logic signed [CW-1:0] r_lox, r_hix, r_loy, r_hiy, r_pyx, r_pyy;
    logic                 r_miy, r_m_vld;

    always_ff @(posedge i_clk) begin
        r_lox <= n_lox;
        r_hix <= n_hix;
        r_loy <= n_loy;
        r_hiy <= n_hiy;
        r_pyx <= w_pyx;
        r_pyy <= w_pyy;
        r_miy <= w_miy;
    end

    // merge y-axis extremum point into the output registers
    logic signed [CW-1:0] n_min_x, n_max_x, n_min_y, n_max_y;

    always_comb begin
        n_min_x = r_lox;
        n_max_x = r_hix;
        n_min_y = r_loy;
        n_max_y = r_hiy;
        if (r_miy) begin
            if (r_pyx < n_min_x) n_min_x = r_pyx;
            if (r_pyx > n_max_x) n_max_x = r_pyx;
            if (r_pyy < n_min_y) n_min_y = r_pyy;
            if (r_pyy > n_max_y) n_max_y = r_pyy;
        end
    end

    logic signed [CW-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic                 r_o_valid;

    always_ff @(posedge i_clk) begin
        r_min_x <= n_min_x;
        r_max_x <= n_max_x;
        r_min_y <= n_min_y;
        r_max_y <= n_max_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_m_vld   <= r_vld[DEPTH-1];
            r_o_valid <= r_m_vld;
        end
    end

    assign busy    = 1'b0;
    assign o_valid = r_o_valid;
    assign o_min_x = r_min_x;
    assign o_min_y = r_min_y;
    assign o_max_x = r_max_x;
    assign o_max_y = r_max_y;

endmodule

// ===== design/qbbb_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on qbbb_pkg; one item per cycle.
module qbbb_div #(
    parameter int DEN_BITS = qbbb_pkg::DEF_COORD_BITS + 2,
    parameter int QUO_BITS = qbbb_pkg::DEF_T_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic [DEN_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic [QUO_BITS-1:0] o_quo
);
    import qbbb_pkg::*;

    logic [DEN_BITS-1:0] r_rem [QUO_BITS];
    logic [DEN_BITS-1:0] r_den [QUO_BITS];
    logic [QUO_BITS-1:0] r_quo [QUO_BITS];

    genvar gi;
    generate
        for (gi = 0; gi < QUO_BITS; gi++) begin : g_stage
            logic [DEN_BITS-1:0] w_rem_in;
            logic [DEN_BITS-1:0] w_den_in;
            logic [QUO_BITS-1:0] w_quo_in;
            logic [DEN_BITS:0]   w_rem2;
            logic                w_ge;
            logic [DEN_BITS:0]   w_diff;

            if (gi == 0) begin : g_first
                assign w_rem_in = i_num;
                assign w_den_in = i_den;
                assign w_quo_in = '0;
            end else begin : g_next
                assign w_rem_in = r_rem[gi-1];
                assign w_den_in = r_den[gi-1];
                assign w_quo_in = r_quo[gi-1];
            end

            // shift remainder, subtract divisor when it fits
            assign w_rem2 = {w_rem_in, 1'b0};
            assign w_ge   = (w_rem2 >= {1'b0, w_den_in});
            assign w_diff = w_rem2 - {1'b0, w_den_in};

            always_ff @(posedge i_clk) begin
                r_rem[gi] <= w_ge ? w_diff[DEN_BITS-1:0] : w_rem2[DEN_BITS-1:0];
                r_den[gi] <= w_den_in;
                r_quo[gi] <= {w_quo_in[QUO_BITS-2:0], w_ge};
            end
        end
    endgenerate

    assign o_quo = r_quo[QUO_BITS-1];

endmodule

// ===== design/qbbb_eval.sv =====
// Three-stage evaluator of one quadratic Bezier coordinate at parameter t,
// rounded to nearest, ties up. Depends on qbbb_pkg.
module qbbb_eval #(
    parameter int COORD_BITS  = qbbb_pkg::DEF_COORD_BITS,
    parameter int T_FRAC_BITS = qbbb_pkg::DEF_T_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic signed [COORD_BITS-1:0] i_a,
    input  logic signed [COORD_BITS-1:0] i_b,
    input  logic signed [COORD_BITS-1:0] i_c,
    input  logic        [T_FRAC_BITS-1:0] i_tq,
    output logic signed [COORD_BITS-1:0] o_p
);
    import qbbb_pkg::*;

    localparam int QW = COORD_BITS + T_FRAC_BITS + 3;
    localparam int PW = QW + T_FRAC_BITS + 1;

    logic signed [COORD_BITS+1:0] w_d;
    logic signed [COORD_BITS+1:0] w_ba;
    logic signed [QW-1:0]         w_q;
    logic signed [QW-1:0]         r_q;
    logic        [T_FRAC_BITS-1:0] r_tq;
    logic signed [COORD_BITS-1:0] r_a1;
    logic signed [COORD_BITS-1:0] r_a2;
    logic signed [PW-1:0]         r_p;
    logic signed [COORD_BITS-1:0] r_out;

    // q = 2(b-a)*2^T + (a-2b+c)*t
    assign w_d  = (COORD_BITS+2)'(i_a) - ((COORD_BITS+2)'(i_b) <<< 1) + (COORD_BITS+2)'(i_c);
    assign w_ba = (COORD_BITS+2)'(i_b) - (COORD_BITS+2)'(i_a);
    assign w_q  = (QW'(w_ba) <<< (T_FRAC_BITS + 1))
                + QW'(w_d * $signed({1'b0, i_tq}));

    always_ff @(posedge i_clk) begin
        r_q   <= w_q;
        r_tq  <= i_tq;
        r_a1  <= i_a;
        // t*q plus half of 2^(2T)
        r_p   <= PW'(r_q * $signed({1'b0, r_tq}))
               + (PW'(1) <<< (2 * T_FRAC_BITS - 1));
        r_a2  <= r_a1;
        // point stays in the hull, so low bits of the sum are exact
        r_out <= r_a2 + r_p[2*T_FRAC_BITS +: COORD_BITS];
    end

    assign o_p = r_out;

endmodule
